FILE: rtl/core/ipht_pkg.sv
// Shared constants, types and the bucket hash for the IPv4 port hash table.
package ipht_pkg;

	localparam int BUCKETS     = 1024;
	localparam int WAYS        = 4;
	localparam int BUCKET_BITS = $clog2(BUCKETS);
	localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int MODE_W      = 2;
	localparam int KEY_W       = 32;
	localparam int PORT_W      = 16;
	localparam int HASH_MULT   = 59;

	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef struct packed {
		logic              vld;
		logic [KEY_W-1:0]  key;
		logic [PORT_W-1:0] port;
	} way_t;

	typedef way_t [WAYS-1:0] row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		logic                   clr;
		logic [BUCKET_BITS-1:0] clr_addr;
		logic                   take;
		logic                   eval;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	function automatic logic [BUCKET_BITS-1:0] bucket_of(input logic [KEY_W-1:0] addr);
		logic [9:0]  sum;
		logic [15:0] prod;
		sum  = 10'(addr[31:24]) + 10'(addr[23:16]) + 10'(addr[15:8]) + 10'(addr[7:0]);
		prod = 16'(sum) * 16'(HASH_MULT);
		return prod[BUCKET_BITS-1:0];
	endfunction

endpackage

FILE: rtl/core/ipht_req_if.sv
// Request channel of the IPv4 port hash table.
interface ipht_req_if;
	logic                          valid;
	logic                          ready;
	logic [ipht_pkg::MODE_W-1:0]   mode;
	logic [ipht_pkg::KEY_W-1:0]    ip_address;
	logic [ipht_pkg::PORT_W-1:0]   port_value;

	modport source(output valid, output mode, output ip_address, output port_value,
		input ready);
	modport sink(input valid, input mode, input ip_address, input port_value,
		output ready);
endinterface

FILE: rtl/core/ipht_rsp_if.sv
// Result channel of the IPv4 port hash table.
interface ipht_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [ipht_pkg::PORT_W-1:0]   port_out;
	logic                          status;

	modport source(output valid, output found, output port_out, output status,
		input ready);
	modport sink(input valid, input found, input port_out, input status,
		output ready);
endinterface

FILE: rtl/core/ipht_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ipht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/ipht_ctrl.sv
// Controller: table clearing sweep after reset and request sequencing.
module ipht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  ipht_pkg::sts_t    sts,
	output ipht_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EVAL  = 2'd2;

	logic [1:0]                       state_q;
	logic [1:0]                       state_d;
	logic [ipht_pkg::BUCKET_BITS-1:0] clr_cnt_q;
	logic                             last_clr;

	assign last_clr  = (clr_cnt_q == ipht_pkg::BUCKET_BITS'(ipht_pkg::BUCKETS - 1));
	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.clr      = 1'b0;
		cmd.clr_addr = clr_cnt_q;
		cmd.take     = 1'b0;
		cmd.eval     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (last_clr) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.out_free) begin
					cmd.eval = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/ipht_dp.sv
// Datapath: bucket memory, way compare, row update and result register.
module ipht_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ipht_pkg::cmd_t                cmd,
	output ipht_pkg::sts_t                sts,
	input  logic [ipht_pkg::MODE_W-1:0]   req_mode,
	input  logic [ipht_pkg::KEY_W-1:0]    req_addr,
	input  logic [ipht_pkg::PORT_W-1:0]   req_port,
	ipht_rsp_if.source                    rsp
);

	logic [ipht_pkg::MODE_W-1:0]      mode_q;
	logic [ipht_pkg::KEY_W-1:0]       addr_q;
	logic [ipht_pkg::PORT_W-1:0]      port_q;
	logic [ipht_pkg::BUCKET_BITS-1:0] bucket_q;
	logic                             out_valid_q;
	logic                             found_q;
	logic [ipht_pkg::PORT_W-1:0]      port_out_q;
	logic                             status_q;

	logic [ipht_pkg::BUCKET_BITS-1:0] rd_addr;
	logic [ipht_pkg::ROW_W-1:0]       rd_data;
	ipht_pkg::row_t                   row;
	ipht_pkg::row_t                   new_row;
	logic                             hit;
	logic [ipht_pkg::WAY_BITS-1:0]    hit_w;
	logic                             have_free;
	logic [ipht_pkg::WAY_BITS-1:0]    free_w;
	logic                             row_wr;
	logic                             found_d;
	logic [ipht_pkg::PORT_W-1:0]      port_out_d;
	logic                             status_d;
	logic                             wr_en;
	logic [ipht_pkg::BUCKET_BITS-1:0] wr_addr;
	logic [ipht_pkg::ROW_W-1:0]       wr_data;

	assign rd_addr = ipht_pkg::bucket_of(req_addr);
	assign row     = ipht_pkg::row_t'(rd_data);

	ipht_ram #(
		.WIDTH(ipht_pkg::ROW_W),
		.DEPTH(ipht_pkg::BUCKETS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.take),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		hit       = 1'b0;
		hit_w     = '0;
		have_free = 1'b0;
		free_w    = '0;
		for (int w = 0; w < ipht_pkg::WAYS; w++) begin
			if (row[w].vld) begin
				if (!hit && row[w].key == addr_q) begin
					hit   = 1'b1;
					hit_w = ipht_pkg::WAY_BITS'(w);
				end
			end else if (!have_free) begin
				have_free = 1'b1;
				free_w    = ipht_pkg::WAY_BITS'(w);
			end
		end
	end

	always_comb begin
		new_row    = row;
		row_wr     = 1'b0;
		found_d    = 1'b0;
		port_out_d = '0;
		status_d   = ipht_pkg::STATUS_OK;
		case (mode_q)
			ipht_pkg::MODE_LOOKUP: begin
				if (hit) begin
					found_d    = 1'b1;
					port_out_d = row[hit_w].port;
				end
			end
			ipht_pkg::MODE_ADD: begin
				if (hit) begin
					found_d             = 1'b1;
					row_wr              = 1'b1;
					new_row[hit_w].port = port_q;
				end else if (have_free) begin
					row_wr               = 1'b1;
					new_row[free_w].vld  = 1'b1;
					new_row[free_w].key  = addr_q;
					new_row[free_w].port = port_q;
				end else begin
					status_d = ipht_pkg::STATUS_FULL;
				end
			end
			ipht_pkg::MODE_REMOVE: begin
				if (hit) begin
					found_d            = 1'b1;
					row_wr             = 1'b1;
					new_row[hit_w].vld = 1'b0;
				end
			end
			default: begin
				row_wr = 1'b0;
			end
		endcase
	end

	assign wr_en   = cmd.clr || (cmd.eval && row_wr);
	assign wr_addr = cmd.clr ? cmd.clr_addr : bucket_q;
	assign wr_data = cmd.clr ? '0 : ipht_pkg::ROW_W'(new_row);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q   <= req_mode;
			addr_q   <= req_addr;
			port_q   <= req_port;
			bucket_q <= rd_addr;
		end
		if (cmd.eval) begin
			found_q    <= found_d;
			port_out_q <= port_out_d;
			status_q   <= status_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.eval) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || rsp.ready;

	assign rsp.valid    = out_valid_q;
	assign rsp.found    = found_q;
	assign rsp.port_out = port_out_q;
	assign rsp.status   = status_q;

endmodule

FILE: rtl/core/ip_port_hash_table.sv
// Top level of the exact-match IPv4 address to port hash table.
// The req channel carries one request per handshake: a lookup, an add or
// update, or a remove, with the address key and the port to store.
// The rsp channel returns exactly one result per request, in order: found,
// the stored port on a lookup hit, and a full status for a failed add.
// The table holds 1024 buckets of four ways in one memory row per bucket.
// When a request is accepted, its bucket row is read from memory, and in
// the EVAL state all ways are compared and the row is written back.
// The result is registered, so rsp.valid rises after that compare.
// A new request is not accepted until the current one has been evaluated,
// as the controller waits in EVAL before it returns to idle.
// After reset the block sweeps the memory to clear all valid bits, one
// bucket a cycle over all 1024 buckets, and holds req.ready low meanwhile.
// When the receiver stalls, the result register holds its value; the next
// request may still be accepted and read, and its result waits until the
// register frees up.
module ip_port_hash_table (
	input  logic       clk,
	input  logic       arst_n,
	ipht_req_if.sink   req,
	ipht_rsp_if.source rsp
);

	ipht_pkg::cmd_t cmd;
	ipht_pkg::sts_t sts;

	ipht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ipht_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.req_mode(req.mode),
		.req_addr(req.ip_address),
		.req_port(req.port_value),
		.rsp     (rsp)
	);

endmodule
